// ===== hw/rtl/wed_pkg.sv =====
// Shared types and constants for the wheel encoder delta unit.
package wed_pkg;

   localparam int POS_BITS   = 9;
   localparam int DELTA_BITS = POS_BITS + 1;
   localparam int CALC_BITS  = DELTA_BITS + 2;
   localparam int RAW_BITS   = 16;
   localparam int STEP_BITS  = 9;
   localparam int TPR_BITS   = 10;
   localparam int CSR_DATA_BITS = TPR_BITS;

   localparam logic [RAW_BITS-1:0] FRAME_CLEAR_MASK = 16'h0078;
   localparam logic [RAW_BITS-1:0] FRAME_SET_MASK   = 16'h3F7F;

   localparam logic [STEP_BITS-1:0] MAX_STEP_RESET      = 9'd100;
   localparam logic [TPR_BITS-1:0]  TICKS_PER_REV_RESET = 10'd512;

   typedef enum logic [1:0] {
      CSR_MAX_STEP      = 2'd0,
      CSR_TICKS_PER_REV = 2'd1,
      CSR_LEFT_REVERSE  = 2'd2,
      CSR_RIGHT_REVERSE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [POS_BITS-1:0] pos;
      logic                bad;
   } frame_type;

   typedef struct packed {
      logic [STEP_BITS-1:0] max_step;
      logic [TPR_BITS-1:0]  ticks_per_rev;
   } wrap_cfg_type;

   typedef struct packed {
      logic signed [DELTA_BITS-1:0] delta;
      logic                         jump;
   } delta_type;

endpackage

// ===== hw/rtl/wheel_encoder_delta_unit.sv =====
// An accepted request is held in the input register, then its result in the result register that drives the response.
// Throughput: one sample per cycle; the input register and the result register form a
// two-entry pipeline that advances whenever the result slot is empty or being taken.
// Reset: synchronous, active high; clears both valid flags, the stored previous
// positions and timer, and loads the configuration registers with their defaults.
// Top level of the wheel encoder delta unit.
module wheel_encoder_delta_unit #(
   parameter int TIMER_BITS = 16
) (
   input  logic clock,
   input  logic reset,

   // Request stream.
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // req_tdata from bit 0: left_raw (16), right_raw (16), timer_count (TIMER_BITS), zero pad.
   input  logic [((2*wed_pkg::RAW_BITS+TIMER_BITS+7)/8)*8-1:0] req_tdata,

   // Response stream.
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // rsp_tdata from bit 0: left_delta (10), right_delta (10),
   // elapsed_ticks (TIMER_BITS+1), zero pad.
   output logic [((2*wed_pkg::DELTA_BITS+TIMER_BITS+1+7)/8)*8-1:0] rsp_tdata,
   // rsp_tuser from bit 0: left_frame_error, right_frame_error,
   // left_jump_error, right_jump_error.
   output logic [3:0]                              rsp_tuser,

   // Configuration write port.
   input  logic                                    csr_wr_en,
   input  wed_pkg::csr_index_type                  csr_index,
   input  logic [wed_pkg::CSR_DATA_BITS-1:0]       csr_wdata
);
   import wed_pkg::*;

   localparam int RSP_TDATA_BITS = ((2*DELTA_BITS+TIMER_BITS+1+7)/8)*8;

   // Configuration registers.
   logic [STEP_BITS-1:0] max_step_ff, max_step_in;
   logic [TPR_BITS-1:0]  ticks_per_rev_ff, ticks_per_rev_in;
   logic                 left_reverse_ff, left_reverse_in;
   logic                 right_reverse_ff, right_reverse_in;

   // Input stage.
   logic                  in_valid_ff, in_valid_in;
   logic [RAW_BITS-1:0]   in_left_ff, in_left_in;
   logic [RAW_BITS-1:0]   in_right_ff, in_right_in;
   logic [TIMER_BITS-1:0] in_timer_ff, in_timer_in;

   // Sample history; updated as each sample moves into the result register.
   logic [POS_BITS-1:0]   prev_left_ff, prev_left_in;
   logic [POS_BITS-1:0]   prev_right_ff, prev_right_in;
   logic [TIMER_BITS-1:0] prev_timer_ff, prev_timer_in;

   // Result register.
   logic                  out_valid_ff, out_valid_in;
   delta_type             out_left_ff, out_left_in;
   delta_type             out_right_ff, out_right_in;
   logic [TIMER_BITS:0]   out_elapsed_ff, out_elapsed_in;
   logic                  out_left_bad_ff, out_left_bad_in;
   logic                  out_right_bad_ff, out_right_bad_in;

   logic                  req_accept;
   logic                  advance;
   logic                  move;
   frame_type             left_frame;
   frame_type             right_frame;
   wrap_cfg_type          wrap_cfg;
   delta_type             left_result;
   delta_type             right_result;
   logic [TIMER_BITS-1:0] timer_diff;

   // The result slot frees up when it is empty or its transaction completes this cycle,
   // so a new request is taken every cycle unless the response side stalls.
   assign advance    = !out_valid_ff || rsp_tready;
   assign move       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   // Configuration register decode.
   always_comb begin
      max_step_in      = max_step_ff;
      ticks_per_rev_in = ticks_per_rev_ff;
      left_reverse_in  = left_reverse_ff;
      right_reverse_in = right_reverse_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAX_STEP:      max_step_in      = csr_wdata[STEP_BITS-1:0];
            CSR_TICKS_PER_REV: ticks_per_rev_in = csr_wdata[TPR_BITS-1:0];
            CSR_LEFT_REVERSE:  left_reverse_in  = csr_wdata[0];
            CSR_RIGHT_REVERSE: right_reverse_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign wrap_cfg.max_step      = max_step_ff;
   assign wrap_cfg.ticks_per_rev = ticks_per_rev_ff;

   wed_frame_unpack u_left_unpack (
      .raw   (in_left_ff),
      .frame (left_frame)
   );

   wed_frame_unpack u_right_unpack (
      .raw   (in_right_ff),
      .frame (right_frame)
   );

   wed_wrap_delta u_left_delta (
      .now_pos    (left_frame.pos),
      .before_pos (prev_left_ff),
      .reverse    (left_reverse_ff),
      .cfg        (wrap_cfg),
      .result     (left_result)
   );

   wed_wrap_delta u_right_delta (
      .now_pos    (right_frame.pos),
      .before_pos (prev_right_ff),
      .reverse    (right_reverse_ff),
      .cfg        (wrap_cfg),
      .result     (right_result)
   );

   // Elapsed time wraps modulo the timer period; equal readings count as a full period,
   // which is exactly the carry bit set over an all-zero difference.
   assign timer_diff = in_timer_ff - prev_timer_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_left_in  = in_left_ff;
      in_right_in = in_right_ff;
      in_timer_in = in_timer_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_left_in  = req_tdata[RAW_BITS-1:0];
         in_right_in = req_tdata[2*RAW_BITS-1:RAW_BITS];
         in_timer_in = req_tdata[2*RAW_BITS+TIMER_BITS-1:2*RAW_BITS];
      end else if (move) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in     = out_valid_ff;
      out_left_in      = out_left_ff;
      out_right_in     = out_right_ff;
      out_elapsed_in   = out_elapsed_ff;
      out_left_bad_in  = out_left_bad_ff;
      out_right_bad_in = out_right_bad_ff;
      prev_left_in     = prev_left_ff;
      prev_right_in    = prev_right_ff;
      prev_timer_in    = prev_timer_ff;
      if (move) begin
         out_valid_in     = 1'b1;
         out_left_in      = left_result;
         out_right_in     = right_result;
         out_elapsed_in   = {(timer_diff == '0), timer_diff};
         out_left_bad_in  = left_frame.bad;
         out_right_bad_in = right_frame.bad;
         // History always advances, including after frame and jump errors.
         prev_left_in     = left_frame.pos;
         prev_right_in    = right_frame.pos;
         prev_timer_in    = in_timer_ff;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_step_ff      <= MAX_STEP_RESET;
         ticks_per_rev_ff <= TICKS_PER_REV_RESET;
         left_reverse_ff  <= 1'b0;
         right_reverse_ff <= 1'b0;
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         prev_left_ff     <= '0;
         prev_right_ff    <= '0;
         prev_timer_ff    <= '0;
      end else begin
         max_step_ff      <= max_step_in;
         ticks_per_rev_ff <= ticks_per_rev_in;
         left_reverse_ff  <= left_reverse_in;
         right_reverse_ff <= right_reverse_in;
         in_valid_ff      <= in_valid_in;
         out_valid_ff     <= out_valid_in;
         prev_left_ff     <= prev_left_in;
         prev_right_ff    <= prev_right_in;
         prev_timer_ff    <= prev_timer_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_left_ff       <= in_left_in;
      in_right_ff      <= in_right_in;
      in_timer_ff      <= in_timer_in;
      out_left_ff      <= out_left_in;
      out_right_ff     <= out_right_in;
      out_elapsed_ff   <= out_elapsed_in;
      out_left_bad_ff  <= out_left_bad_in;
      out_right_bad_ff <= out_right_bad_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_TDATA_BITS'({out_elapsed_ff, out_right_ff.delta, out_left_ff.delta});
   assign rsp_tuser  = {out_right_ff.jump, out_left_ff.jump, out_right_bad_ff, out_left_bad_ff};

   // A rejected jump always reports a zero change.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_left_ff.jump) |-> (out_left_ff.delta == '0))
      else $error("left jump reported with nonzero delta");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_right_ff.jump) |-> (out_right_ff.delta == '0))
      else $error("right jump reported with nonzero delta");

   // A bad frame is stored as position zero for the next sample.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_left_bad_ff) |-> (prev_left_ff == '0))
      else $error("left frame error did not store position zero");

   // Elapsed time is never zero.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_elapsed_ff != '0))
      else $error("elapsed ticks of zero");

   // The request side only stalls when both pipeline slots are held.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("request stalled with a free pipeline slot");

endmodule

// ===== hw/rtl/wed_frame_unpack.sv =====
// Frame check and position unpack for one raw encoder word.
module wed_frame_unpack (
   input  logic [wed_pkg::RAW_BITS-1:0] raw,
   output wed_pkg::frame_type           frame
);
   import wed_pkg::*;

   logic clear_fail;
   logic set_fail;

   // Bits 6..3 must be clear; bits 15, 14 and 7 must be set.
   assign clear_fail = |(raw & FRAME_CLEAR_MASK);
   assign set_fail   = |(~(raw | FRAME_SET_MASK));

   always_comb begin
      frame.bad = clear_fail || set_fail;
      frame.pos = frame.bad ? '0 : {raw[13:8], raw[2:0]};
   end

endmodule

// ===== hw/rtl/wed_wrap_delta.sv =====
// Wrap-aware signed position change with jump rejection for one wheel.
module wed_wrap_delta (
   input  logic [wed_pkg::POS_BITS-1:0] now_pos,
   input  logic [wed_pkg::POS_BITS-1:0] before_pos,
   input  logic                         reverse,
   input  wed_pkg::wrap_cfg_type        cfg,
   output wed_pkg::delta_type           result
);
   import wed_pkg::*;

   logic signed [CALC_BITS-1:0] now_s;
   logic signed [CALC_BITS-1:0] before_s;
   logic signed [CALC_BITS-1:0] diff;
   logic signed [CALC_BITS-1:0] abs_diff;
   logic signed [CALC_BITS-1:0] mod_s;
   logic signed [CALC_BITS-1:0] lim_s;
   logic signed [CALC_BITS-1:0] rem;
   logic signed [CALC_BITS-1:0] abs_rem;
   logic signed [CALC_BITS-1:0] wrapped;

   always_comb begin
      now_s    = signed'({{(CALC_BITS-POS_BITS){1'b0}}, now_pos});
      before_s = signed'({{(CALC_BITS-POS_BITS){1'b0}}, before_pos});
      mod_s    = signed'({{(CALC_BITS-TPR_BITS){1'b0}}, cfg.ticks_per_rev});
      lim_s    = signed'({{(CALC_BITS-STEP_BITS){1'b0}}, cfg.max_step});
      diff     = reverse ? (before_s - now_s) : (now_s - before_s);
      abs_diff = (diff < 0) ? -diff : diff;
      rem      = mod_s - abs_diff;
      abs_rem  = (rem < 0) ? -rem : rem;
      wrapped  = (diff >= 0) ? (diff - mod_s) : (diff + mod_s);

      // Direct change first, then the change taken the other way round the wheel.
      if (abs_diff <= lim_s) begin
         result.delta = diff[DELTA_BITS-1:0];
         result.jump  = 1'b0;
      end else if (abs_rem <= lim_s) begin
         result.delta = wrapped[DELTA_BITS-1:0];
         result.jump  = 1'b0;
      end else begin
         result.delta = '0;
         result.jump  = 1'b1;
      end
   end

endmodule
